// ----- hw/rtl/qfud_pkg.sv -----
package qfud_pkg;

  // Widest configuration register and the default field name.
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned KEY_LEN_W     = 4;
  localparam int unsigned MAX_KEY_CHARS = 8;
  localparam logic [CFG_DATA_W-1:0] KEY_WORD_RST = 64'd1701080931;
  localparam logic [KEY_LEN_W-1:0]  KEY_LEN_RST  = 4'd4;

  // Configuration register indexes.
  localparam logic CFG_KEY_WORD   = 1'b0;
  localparam logic CFG_KEY_LENGTH = 1'b1;

  // Characters with a meaning to the parser.
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Key position saturates at this value.
  localparam logic [KEY_LEN_W-1:0] KEY_POS_MAX = 4'd15;

  typedef enum logic [2:0] {
    PH_KEY      = 3'd0,
    PH_VALUE    = 3'd1,
    PH_ESC_HIGH = 3'd2,
    PH_ESC_LOW  = 3'd3,
    PH_SKIP     = 3'd4
  } phase_e;

  typedef struct packed {
    phase_e               phase;
    logic [KEY_LEN_W-1:0] key_pos;
    logic                 key_match;
    logic [3:0]           high_nib;
    logic                 nib_bad;
  } parse_state_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       value_done;
    logic       bad_escape;
  } result_t;

  // Hex digit value; bit 4 flags a character that is not a hex digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
      return {1'b0, v[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
      return {1'b0, v[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
      return {1'b0, v[3:0]};
    end
    return 5'b10000;
  endfunction

endpackage

// ----- hw/rtl/qfud_step.sv -----
module qfud_step #(
  parameter int unsigned MaxKeyChars = qfud_pkg::MAX_KEY_CHARS
) (
  input  qfud_pkg::parse_state_t        cur_i,
  input  logic [7:0]                    in_byte_i,
  input  logic                          is_last_i,
  input  logic [8*MaxKeyChars-1:0]      key_word_i,
  input  logic [qfud_pkg::KEY_LEN_W-1:0] key_len_i,
  output qfud_pkg::parse_state_t        nxt_o,
  output qfud_pkg::result_t             res_o
);
  import qfud_pkg::*;

  localparam int unsigned IDX_W = (MaxKeyChars > 1) ? $clog2(MaxKeyChars) : 1;
  localparam logic [KEY_LEN_W-1:0] MAX_POS = KEY_LEN_W'(MaxKeyChars);

  logic [IDX_W-1:0] key_idx;
  logic [7:0]       key_char;
  logic             char_ok;
  logic [4:0]       hex;
  logic             bad_any;

  // Character of the field name at the current key position.
  assign key_idx  = cur_i.key_pos[IDX_W-1:0];
  assign key_char = key_word_i[8*key_idx +: 8];
  assign char_ok  = (cur_i.key_pos < key_len_i) && (cur_i.key_pos < MAX_POS) &&
                    (in_byte_i == key_char);
  assign hex      = hex_nibble(in_byte_i);
  assign bad_any  = cur_i.nib_bad | hex[4];

  // Phase update and result for one byte.
  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    case (cur_i.phase)
      PH_VALUE: begin
        if (in_byte_i == CH_AMP) begin
          res_o.emit       = 1'b1;
          res_o.value_done = 1'b1;
          nxt_o.phase      = PH_KEY;
          nxt_o.key_pos    = '0;
          nxt_o.key_match  = 1'b1;
        end else if (in_byte_i == CH_PCT) begin
          if (is_last_i) begin
            res_o.emit       = 1'b1;
            res_o.value_done = 1'b1;
            res_o.bad_escape = 1'b1;
          end else begin
            nxt_o.phase   = PH_ESC_HIGH;
            nxt_o.nib_bad = 1'b0;
          end
        end else begin
          res_o.emit       = 1'b1;
          res_o.out_byte   = (in_byte_i == CH_PLUS) ? CH_SPACE : in_byte_i;
          res_o.byte_valid = 1'b1;
          res_o.value_done = is_last_i;
        end
      end
      PH_ESC_HIGH: begin
        if (in_byte_i == CH_AMP) begin
          res_o.emit       = 1'b1;
          res_o.value_done = 1'b1;
          res_o.bad_escape = 1'b1;
          nxt_o.phase      = PH_KEY;
          nxt_o.key_pos    = '0;
          nxt_o.key_match  = 1'b1;
        end else begin
          nxt_o.high_nib = hex[3:0];
          nxt_o.nib_bad  = bad_any;
          if (is_last_i) begin
            res_o.emit       = 1'b1;
            res_o.value_done = 1'b1;
            res_o.bad_escape = 1'b1;
          end else begin
            nxt_o.phase = PH_ESC_LOW;
          end
        end
      end
      PH_ESC_LOW: begin
        if (in_byte_i == CH_AMP) begin
          res_o.emit       = 1'b1;
          res_o.value_done = 1'b1;
          res_o.bad_escape = 1'b1;
          nxt_o.phase      = PH_KEY;
          nxt_o.key_pos    = '0;
          nxt_o.key_match  = 1'b1;
        end else begin
          nxt_o.nib_bad    = bad_any;
          res_o.emit       = 1'b1;
          res_o.out_byte   = {cur_i.high_nib, hex[3:0]};
          res_o.byte_valid = 1'b1;
          res_o.value_done = is_last_i;
          res_o.bad_escape = bad_any;
          nxt_o.phase      = PH_VALUE;
        end
      end
      PH_SKIP: begin
        if (in_byte_i == CH_AMP) begin
          nxt_o.phase     = PH_KEY;
          nxt_o.key_pos   = '0;
          nxt_o.key_match = 1'b1;
        end
      end
      default: begin
        // Key scanning; unused phase codes land here too.
        nxt_o.phase = PH_KEY;
        if (in_byte_i == CH_EQ) begin
          if (cur_i.key_match && (cur_i.key_pos == key_len_i)) begin
            nxt_o.phase = PH_VALUE;
            if (is_last_i) begin
              res_o.emit       = 1'b1;
              res_o.value_done = 1'b1;
            end
          end else begin
            nxt_o.phase = PH_SKIP;
          end
        end else begin
          if (!char_ok) begin
            nxt_o.key_match = 1'b0;
          end
          if (cur_i.key_pos != KEY_POS_MAX) begin
            nxt_o.key_pos = cur_i.key_pos + 1'b1;
          end
        end
      end
    endcase

    // The end of the string always restarts key scanning.
    if (is_last_i) begin
      nxt_o.phase     = PH_KEY;
      nxt_o.key_pos   = '0;
      nxt_o.key_match = 1'b1;
    end
  end

endmodule

// ----- hw/rtl/query_field_url_decoder.sv -----
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-----------------------------------------
// in       | input     | in_valid_i / in_ready_o    | in_byte_i, is_last_i
// out      | output    | out_valid_o / out_ready_i  | out_byte_o, byte_valid_o, value_done_o,
//          |           |                            | bad_escape_o
// cfg      | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// One byte is accepted per cycle while the output register is empty or being drained; its result,
// if any, appears in the output register on the next cycle.
// The parse state, the configuration registers and the output register are the only stored elements.
// Reset returns the parser to key scanning and loads the default field name.
// A new beat is taken while the output register is empty or being drained.
module query_field_url_decoder #(
  parameter int unsigned MaxKeyChars = qfud_pkg::MAX_KEY_CHARS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      in_byte_i,
  input  logic                            is_last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      out_byte_o,
  output logic                            byte_valid_o,
  output logic                            value_done_o,
  output logic                            bad_escape_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [qfud_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import qfud_pkg::*;

  localparam int unsigned KEY_W = 8 * MaxKeyChars;

  logic [KEY_W-1:0]     key_word_q;
  logic [KEY_LEN_W-1:0] key_len_q;
  parse_state_t         state_q, state_d;
  result_t              res;
  logic                 out_valid_q;
  result_t              out_q;
  logic                 accept;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_word_q <= KEY_WORD_RST[KEY_W-1:0];
      key_len_q  <= KEY_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_WORD:   key_word_q <= cfg_data_i[KEY_W-1:0];
        CFG_KEY_LENGTH: key_len_q  <= cfg_data_i[KEY_LEN_W-1:0];
        default:        key_len_q  <= key_len_q;
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  qfud_step #(
    .MaxKeyChars(MaxKeyChars)
  ) u_step (
    .cur_i     (state_q),
    .in_byte_i (in_byte_i),
    .is_last_i (is_last_i),
    .key_word_i(key_word_q),
    .key_len_i (key_len_q),
    .nxt_o     (state_d),
    .res_o     (res)
  );

  // Parse state advances on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= PH_KEY;
      state_q.key_pos   <= '0;
      state_q.key_match <= 1'b1;
      state_q.high_nib  <= '0;
      state_q.nib_bad   <= 1'b0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= accept && res.emit;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (accept && res.emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_q.out_byte;
  assign byte_valid_o = out_q.byte_valid;
  assign value_done_o = out_q.value_done;
  assign bad_escape_o = out_q.bad_escape;

  // A result without a character always closes a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> value_done_o)
    else $error("result without byte does not close a value");

  // A result without a character carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> out_byte_o == 8'd0)
    else $error("empty result carries a nonzero byte");

  // The end of a string restarts key scanning with a fresh comparison.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_last_i |=> state_q.phase == PH_KEY && state_q.key_pos == '0 &&
                            state_q.key_match)
    else $error("parser did not restart after the last byte");

  // A result appears only after an accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(out_valid_q) && out_valid_q |-> $past(accept))
    else $error("result appeared without an accepted beat");

endmodule
